// ===== hw/rtl/cbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell balance controller package
// Shared widths, event codes, controller states and result type.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int SOC_W          = 16;
  localparam int NUM_SOC_FIELDS = 6;
  localparam int MASK_W         = 6;
  localparam int OP_W           = 2;
  localparam int CODE_W         = 2;

  localparam logic [SOC_W-1:0] THR_RESET = 16'd1311;

  localparam logic [OP_W-1:0] OP_CV_START = 2'd0;
  localparam logic [OP_W-1:0] OP_CV_STOP  = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

  localparam logic [CODE_W-1:0] CODE_IDLE   = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DETECT = 2'd1;
  localparam logic [CODE_W-1:0] CODE_EQUAL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DETECT = 3'b010,
    ST_EQUAL  = 3'b100
  } state_t;

  typedef logic [SOC_W-1:0] soc_t;

  typedef struct packed {
    logic [CODE_W-1:0] fsm_state;
    logic [MASK_W-1:0] bypass_mask;
    logic              pack_unbalanced;
  } result_t;

  function automatic logic [CODE_W-1:0] state_code(input state_t st);
    logic [CODE_W-1:0] code;
    unique case (st)
      ST_IDLE:   code = CODE_IDLE;
      ST_DETECT: code = CODE_DETECT;
      ST_EQUAL:  code = CODE_EQUAL;
      default:   code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/cbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell balance controller channels
// Valid/ready request channels for snapshots in and results out.
// ----------------------------------------------------------------------------
interface cbc_in_if import cbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SOC_W-1:0]  soc_cell0;
  logic [SOC_W-1:0]  soc_cell1;
  logic [SOC_W-1:0]  soc_cell2;
  logic [SOC_W-1:0]  soc_cell3;
  logic [SOC_W-1:0]  soc_cell4;
  logic [SOC_W-1:0]  soc_cell5;

  modport source (output valid, op, soc_cell0, soc_cell1, soc_cell2, soc_cell3,
                  soc_cell4, soc_cell5, input ready);
  modport sink   (input valid, op, soc_cell0, soc_cell1, soc_cell2, soc_cell3,
                  soc_cell4, soc_cell5, output ready);
endinterface

interface cbc_out_if import cbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] fsm_state;
  logic [MASK_W-1:0] bypass_mask;
  logic              pack_unbalanced;

  modport source (output valid, fsm_state, bypass_mask, pack_unbalanced, input ready);
  modport sink   (input valid, fsm_state, bypass_mask, pack_unbalanced, output ready);
endinterface

// ===== hw/rtl/cbc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell balance lane
// Flags one cell whose SOC sits more than the threshold above the pack minimum.
// ----------------------------------------------------------------------------
module cbc_lane import cbc_pkg::*; (
  input  soc_t soc,
  input  soc_t soc_min,
  input  soc_t thr,
  output logic over
);

  soc_t diff;

  assign diff = soc - soc_min;
  assign over = (diff > thr);

endmodule

// ===== hw/rtl/cbc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell balance merge and state machine
// Combines lane flags into the bypass mask, checks pack imbalance and
// advances the idle / detecting / equalizing controller.
// ----------------------------------------------------------------------------
module cbc_merge import cbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [OP_W-1:0]   op,
  input  soc_t              soc_min,
  input  soc_t              soc_max,
  input  soc_t              thr,
  input  logic [MASK_W-1:0] lane_mask,
  output result_t           res
);

  state_t            state_r, state_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              unb;
  soc_t              spread;

  assign spread = soc_max - soc_min;
  assign unb    = (spread > thr);

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    unique case (op)
      OP_CV_START: begin
        if (state_r == ST_IDLE) begin
          if (unb) begin
            state_nxt = ST_EQUAL;
            mask_nxt  = lane_mask;
          end else begin
            state_nxt = ST_DETECT;
          end
        end
      end
      OP_CV_STOP: begin
        state_nxt = ST_IDLE;
      end
      OP_RUN: begin
        unique case (state_r)
          ST_DETECT: begin
            if (unb) begin
              state_nxt = ST_EQUAL;
              mask_nxt  = lane_mask;
            end
          end
          ST_EQUAL: begin
            if (unb) begin
              mask_nxt = lane_mask;
            end else begin
              state_nxt = ST_DETECT;
              mask_nxt  = '0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mask_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign res.fsm_state       = state_code(state_nxt);
  assign res.bypass_mask     = mask_nxt;
  assign res.pack_unbalanced = unb;

`ifndef NO_ASSERTIONS
  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step && op == OP_CV_STOP |=> state_r == ST_IDLE && mask_r == $past(mask_r))
    else $error("charging stop did not idle with mask held");

  a_balanced_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && op == OP_RUN && state_r == ST_EQUAL && !unb
    |=> state_r == ST_DETECT && mask_r == '0)
    else $error("balanced pack did not clear mask and return to detecting");

  a_idle_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && op == OP_RUN && state_r == ST_IDLE
    |=> state_r == ST_IDLE && mask_r == $past(mask_r))
    else $error("run while idle changed state");
`endif

endmodule

// ===== hw/rtl/cell_balance_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell balance controller
// Passive balancing control over one SOC snapshot per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns one
// result per request: the first stage registers the snapshot with its minimum
// and maximum SOC, the second runs one compare lane per cell, merges the lane
// flags into the bypass mask and steps the controller state into the output
// register. Under output back-pressure both stages stall, though an empty first
// stage still takes a request while a finished result waits. The threshold is written
// through cfg_wr_en / cfg_wr_data and must only change while the block is idle.
module cell_balance_controller import cbc_pkg::*; #(
  parameter int CELLS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SOC_W-1:0]  cfg_wr_data,
  cbc_in_if.sink            in_if,
  cbc_out_if.source         out_if
);

  localparam int USED = (CELLS > NUM_SOC_FIELDS) ? NUM_SOC_FIELDS : CELLS;

  soc_t              thr_r;
  soc_t              soc_in [NUM_SOC_FIELDS];
  soc_t              soc_r  [USED];
  soc_t              min_in, max_in;
  soc_t              min_r, max_r;
  logic [OP_W-1:0]   op_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           res;
  logic [MASK_W-1:0] lane_mask;
  logic              lane_over [USED];
  logic              out_free;
  logic              s1_adv;
  logic              step;

  assign soc_in[0] = in_if.soc_cell0;
  assign soc_in[1] = in_if.soc_cell1;
  assign soc_in[2] = in_if.soc_cell2;
  assign soc_in[3] = in_if.soc_cell3;
  assign soc_in[4] = in_if.soc_cell4;
  assign soc_in[5] = in_if.soc_cell5;

  assign out_free    = !out_valid_r || out_if.ready;
  assign step        = s1_valid_r && out_free;
  assign s1_adv      = !s1_valid_r || out_free;
  assign in_if.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    min_in = '1;
    max_in = '0;
    for (int i = 0; i < USED; i++) begin
      if (soc_in[i] < min_in) min_in = soc_in[i];
      if (soc_in[i] > max_in) max_in = soc_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_if.valid) begin
      op_r  <= in_if.op;
      min_r <= min_in;
      max_r <= max_in;
      for (int i = 0; i < USED; i++) begin
        soc_r[i] <= soc_in[i];
      end
    end
  end

  always_comb begin
    lane_mask = '0;
    for (int i = 0; i < USED; i++) begin
      lane_mask[USED-1-i] = lane_over[i];
    end
  end

  for (genvar g = 0; g < USED; g++) begin : g_lane
    cbc_lane u_lane (
      .soc     (soc_r[g]),
      .soc_min (min_r),
      .thr     (thr_r),
      .over    (lane_over[g])
    );
  end

  cbc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .op        (op_r),
    .soc_min   (min_r),
    .soc_max   (max_r),
    .thr       (thr_r),
    .lane_mask (lane_mask),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.fsm_state       = out_r.fsm_state;
  assign out_if.bypass_mask     = out_r.bypass_mask;
  assign out_if.pack_unbalanced = out_r.pack_unbalanced;

endmodule
